// ----- design/pft_pkg.sv -----
// shared types and constants of the lamp fade controller
// field widths, command codes, payload structs and controller/datapath links
`default_nettype none

package pft_pkg;

	localparam int LEVEL_BITS   = 16;
	localparam int TICK_BITS    = 24;
	localparam int PCT_BITS     = 7;
	localparam int PROD_BITS    = LEVEL_BITS + PCT_BITS;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 24;

	localparam logic [PCT_BITS-1:0]  PCT_MAX     = PCT_BITS'(99);

	// divide by 100 as a multiply by ceil(2^30/100) and a shift by 30,
	// exact for every product below 2^23
	localparam int                    RECIP_BITS  = 24;
	localparam int                    RECIP_SHIFT = 30;
	localparam logic [RECIP_BITS-1:0] PCT_RECIP   = RECIP_BITS'(10737419);

	localparam logic [LEVEL_BITS-1:0] MAX_LEVEL_RESET  = LEVEL_BITS'(65535);
	localparam logic [TICK_BITS-1:0]  RAMP_TICKS_RESET = TICK_BITS'(5000000);

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LEVEL  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_TICKS = 1'b1;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_FADE = 2'd1,
		KIND_OFF  = 2'd2,
		KIND_NOP  = 2'd3
	} kind_t;

	// divider operand selection
	typedef enum logic {
		DIV_STEP = 1'b0,
		DIV_MOD  = 1'b1
	} div_sel_t;

	typedef struct packed {
		kind_t               kind;
		logic [PCT_BITS-1:0] percent;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] duty;
		logic                  busy_res;
		logic                  lamp_enable;
		logic                  ramp_done;
		logic                  ignored;
	} out_item_t;

	typedef struct packed {
		logic     load_in;
		logic     set_dropped;
		logic     mul_ld;
		logic     div_start;
		div_sel_t div_sel;
		logic     set_target;
		logic     set_step;
		logic     set_lmod;
		logic     start_ramp;
		logic     tick_upd;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  ramping;
		logic  up;
		logic  lmod_stale;
		logic  div_done;
		logic  target_eq;
		logic  out_free;
	} status_t;

endpackage

`default_nettype wire

// ----- design/pft_div.sv -----
// serial restoring divider, one quotient bit per cycle
// uses pft_pkg for the operand width
`default_nettype none

module pft_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pft_pkg::TICK_BITS-1:0] dividend,
	input  wire logic [pft_pkg::TICK_BITS-1:0] divisor,
	output logic                               done,
	output logic      [pft_pkg::TICK_BITS-1:0] quotient,
	output logic      [pft_pkg::TICK_BITS-1:0] remainder
);

	localparam int W  = pft_pkg::TICK_BITS;
	localparam int CW = $clog2(W);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  divisor_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0] shifted;
	logic [W:0] diff;
	logic       fits;

	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff    = shifted - {1'b0, divisor_q};
		fits    = shifted >= {1'b0, divisor_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? diff[W-1:0] : shifted[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider started while still busy");

endmodule

`default_nettype wire

// ----- design/pft_dpath.sv -----
// datapath of the lamp fade controller: configuration, ramp state,
// target product, shared divider and output register; uses pft_pkg and pft_div
`default_nettype none

module pft_dpath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [pft_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [pft_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  wire pft_pkg::in_item_t                 in_item,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output pft_pkg::out_item_t                     out_item,
	input  wire pft_pkg::cmd_t                     cmd,
	output pft_pkg::status_t                       status
);

	localparam int LW  = pft_pkg::LEVEL_BITS;
	localparam int TW  = pft_pkg::TICK_BITS;
	localparam int PW  = pft_pkg::PCT_BITS;
	localparam int PRW = pft_pkg::PROD_BITS;
	localparam int RW  = pft_pkg::PROD_BITS + pft_pkg::RECIP_BITS;

	// configuration
	logic [LW-1:0] max_level_q;
	logic [TW-1:0] ramp_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q  <= pft_pkg::MAX_LEVEL_RESET;
			ramp_ticks_q <= pft_pkg::RAMP_TICKS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pft_pkg::CFG_MAX_LEVEL:  max_level_q  <= cfg_data[LW-1:0];
				pft_pkg::CFG_RAMP_TICKS: ramp_ticks_q <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	// latched item
	pft_pkg::kind_t            kind_q;
	logic [PW-1:0]             pct_q;
	logic [pft_pkg::PROD_BITS-1:0] product_q;

	// ramp state
	logic [LW-1:0] settled_q;
	logic [LW-1:0] target_q;
	logic [LW:0]   working_q;
	logic [TW-1:0] tick_q;
	logic [TW-1:0] step_q;
	logic [TW-1:0] rem_q;
	logic [TW-1:0] lmod_q;
	logic          lmod_stale_q;
	logic          up_q;
	logic          ramping_q;
	logic          enable_q;
	logic          off_q;
	logic [LW-1:0] duty_q;
	logic          done_q;
	logic          dropped_q;

	// output register
	logic               out_valid_q;
	pft_pkg::out_item_t out_q;

	logic [TW-1:0] len;
	logic          up_w;
	logic [LW-1:0] diff_w;
	logic [TW-1:0] tick_n;
	logic [TW-1:0] rem_inc;
	logic [TW-1:0] rem_n;
	logic          move;
	logic          last;
	logic [LW:0]   target_ext;
	logic [LW:0]   working_n;
	logic [RW-1:0] recip_w;
	logic [LW-1:0] target_w;

	logic          div_done;
	logic [TW-1:0] div_quo;
	logic [TW-1:0] div_rem;
	logic [TW-1:0] div_dividend;
	logic [TW-1:0] div_divisor;

	always_comb begin
		len        = (ramp_ticks_q == '0) ? TW'(1) : ramp_ticks_q;
		up_w       = target_q > settled_q;
		diff_w     = up_w ? (target_q - settled_q) : (settled_q - target_q);
		target_ext = {1'b0, target_q};

		// percent of full scale divided by 100 through the reciprocal
		recip_w  = RW'(product_q) * RW'(pft_pkg::PCT_RECIP);
		target_w = recip_w[pft_pkg::RECIP_SHIFT +: LW];

		// tick count modulo step, tracked without a divide; going down the
		// position is a multiple of step when the count matches len mod step
		tick_n  = tick_q + TW'(1);
		rem_inc = rem_q + TW'(1);
		rem_n   = (rem_inc == step_q) ? '0 : rem_inc;
		move    = up_q ? (rem_n == '0) : (rem_n == lmod_q);
		last    = (tick_n >= len) || (tick_n == '0);

		working_n = working_q;
		if (move) begin
			if (up_q && (working_q < target_ext)) begin
				working_n = working_q + (LW+1)'(1);
			end else if (!up_q && (working_q > target_ext)) begin
				working_n = working_q - (LW+1)'(1);
			end
		end
	end

	always_comb begin
		unique case (cmd.div_sel)
			pft_pkg::DIV_STEP: begin
				div_dividend = len;
				div_divisor  = TW'(diff_w);
			end
			pft_pkg::DIV_MOD: begin
				div_dividend = len;
				div_divisor  = step_q;
			end
		endcase
	end

	pft_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// item capture and product
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= in_item.kind;
			if (in_item.kind == pft_pkg::KIND_OFF) begin
				pct_q <= '0;
			end else if (in_item.percent > pft_pkg::PCT_MAX) begin
				pct_q <= pft_pkg::PCT_MAX;
			end else begin
				pct_q <= in_item.percent;
			end
		end
		if (cmd.mul_ld) begin
			product_q <= PRW'(max_level_q) * PRW'(pct_q);
		end
	end

	// phase registers need no reset, they are loaded at ramp start
	always_ff @(posedge clk) begin
		if (cmd.start_ramp) begin
			rem_q <= '0;
		end else if (cmd.tick_upd) begin
			rem_q <= rem_n;
		end
		if (cmd.start_ramp || cmd.set_lmod) begin
			lmod_q <= div_rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settled_q    <= '0;
			target_q     <= '0;
			working_q    <= '0;
			tick_q       <= '0;
			step_q       <= TW'(1);
			up_q         <= 1'b1;
			ramping_q    <= 1'b0;
			enable_q     <= 1'b0;
			off_q        <= 1'b0;
			duty_q       <= '0;
			done_q       <= 1'b0;
			dropped_q    <= 1'b0;
			lmod_stale_q <= 1'b0;
		end else begin
			// a new ramp length invalidates len mod step
			if (cfg_we && (cfg_index == pft_pkg::CFG_RAMP_TICKS)) begin
				lmod_stale_q <= 1'b1;
			end else if (cmd.start_ramp || cmd.set_lmod) begin
				lmod_stale_q <= 1'b0;
			end
			if (cmd.load_in) begin
				done_q    <= 1'b0;
				dropped_q <= 1'b0;
			end
			if (cmd.set_dropped) begin
				dropped_q <= 1'b1;
			end
			if (cmd.mul_ld) begin
				enable_q <= 1'b1;
			end
			if (cmd.set_target) begin
				target_q <= target_w;
			end
			if (cmd.set_step) begin
				step_q <= (div_quo == '0) ? TW'(1) : div_quo;
			end
			if (cmd.start_ramp) begin
				up_q      <= up_w;
				working_q <= {1'b0, settled_q};
				tick_q    <= '0;
				off_q     <= (kind_q == pft_pkg::KIND_OFF);
				ramping_q <= 1'b1;
			end
			if (cmd.tick_upd) begin
				tick_q <= tick_n;
				if (last) begin
					duty_q    <= target_q;
					working_q <= target_ext;
					settled_q <= target_q;
					ramping_q <= 1'b0;
					off_q     <= 1'b0;
					done_q    <= 1'b1;
					if (off_q) begin
						enable_q <= 1'b0;
					end
				end else begin
					working_q <= working_n;
					if (move) begin
						duty_q <= working_n[LW-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.duty        <= duty_q;
			out_q.busy_res    <= ramping_q;
			out_q.lamp_enable <= enable_q;
			out_q.ramp_done   <= done_q;
			out_q.ignored     <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		status.kind       = kind_q;
		status.ramping    = ramping_q;
		status.up         = up_q;
		status.lmod_stale = lmod_stale_q;
		status.div_done   = div_done;
		status.target_eq  = (target_q == settled_q);
		status.out_free   = !out_valid_q || out_ready;
	end

	a_phase_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ramping_q |-> (rem_q < step_q))
		else $error("tick phase outside step size during ramp");

	a_done_ends_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(ramping_q) |-> done_q)
		else $error("ramp ended without ramp_done");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !ramping_q)
		else $error("ramp_done while still ramping");

	a_drop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q |-> ramping_q)
		else $error("command flagged as ignored while idle");

endmodule

`default_nettype wire

// ----- design/pft_ctrl.sv -----
// sequencing state machine of the lamp fade controller
// drives the datapath command struct from its status struct; uses pft_pkg
`default_nettype none

module pft_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire pft_pkg::status_t status,
	output pft_pkg::cmd_t         cmd
);

	typedef enum logic [8:0] {
		S_IDLE       = 9'b000000001,
		S_DECODE     = 9'b000000010,
		S_TARGET     = 9'b000000100,
		S_PHASE_WAIT = 9'b000001000,
		S_CHECK      = 9'b000010000,
		S_STEP_WAIT  = 9'b000100000,
		S_MOD_GO     = 9'b001000000,
		S_MOD_WAIT   = 9'b010000000,
		S_EMIT       = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   is_cmd;
	logic   is_tick;

	always_comb begin
		is_cmd   = (status.kind == pft_pkg::KIND_FADE) || (status.kind == pft_pkg::KIND_OFF);
		is_tick  = (status.kind == pft_pkg::KIND_TICK);
		state_d  = state_q;
		cmd      = '0;
		cmd.div_sel = pft_pkg::DIV_STEP;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (is_tick && status.ramping && !status.up && status.lmod_stale) begin
					// ramp length changed: refresh len mod step first
					cmd.div_start = 1'b1;
					cmd.div_sel   = pft_pkg::DIV_MOD;
					state_d       = S_PHASE_WAIT;
				end else if (is_tick && status.ramping) begin
					cmd.tick_upd = 1'b1;
					state_d      = S_EMIT;
				end else if (is_cmd && status.ramping) begin
					cmd.set_dropped = 1'b1;
					state_d         = S_EMIT;
				end else if (is_cmd) begin
					cmd.mul_ld = 1'b1;
					state_d    = S_TARGET;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_TARGET: begin
				cmd.set_target = 1'b1;
				state_d        = S_CHECK;
			end
			S_PHASE_WAIT: begin
				if (status.div_done) begin
					cmd.set_lmod = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_CHECK: begin
				if (status.target_eq) begin
					state_d = S_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = pft_pkg::DIV_STEP;
					state_d       = S_STEP_WAIT;
				end
			end
			S_STEP_WAIT: begin
				if (status.div_done) begin
					cmd.set_step = 1'b1;
					state_d      = S_MOD_GO;
				end
			end
			S_MOD_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = pft_pkg::DIV_MOD;
				state_d       = S_MOD_WAIT;
			end
			S_MOD_WAIT: begin
				if (status.div_done) begin
					cmd.start_ramp = 1'b1;
					state_d        = S_EMIT;
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- design/pwm_fade_to_level.sv -----
// top level of the lamp fade controller
// joins pft_ctrl and pft_dpath; types and constants from pft_pkg
//
// lamp fade controller: each transfer on the input is a tick, a fade to a
// percent (0..99, larger values saturate), a fade off or a no-op code, and each
// gives exactly one result transfer holding duty, busy, lamp enable, ramp done
// and ignored. a fade sets the target to max_level*percent/100 and, if it
// differs from the settled level, starts a ramp of ramp_ticks ticks whose duty
// steps one count every step_size ticks and lands on the target at the last
// tick. commands during a ramp are dropped and flagged. a tick, a no-op code or
// a dropped command passes through accept, decode and update, and output load.
// the target comes from a reciprocal multiply, so a command at the current
// level passes through accept, decode with the product load, target, check and
// output load. a fade that starts a ramp runs the one shared 24-step restoring
// divider twice in series, for the step size and for ramp_ticks modulo the
// step. a tick of a downward ramp after a ramp_ticks write reruns the modulo
// first. a result waiting in the output register holds the sequencer at the
// output load; the next input transfer is taken while that result still waits.
// configuration writes land at once and belong in idle periods
`default_nettype none

module pwm_fade_to_level (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_we,
	input  wire logic [pft_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [pft_pkg::CFG_DATA_BITS-1:0] cfg_data,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire pft_pkg::in_item_t                 in_item,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output pft_pkg::out_item_t                     out_item
);

	// command and status between sequencer and datapath
	pft_pkg::cmd_t    cmd;
	pft_pkg::status_t status;

	pft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath holds the registers, the ramp state and the output stage
	pft_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

`default_nettype wire

// ----- verif/tb_pwm_fade_to_level.sv -----
// self-checking testbench of the lamp fade controller pwm_fade_to_level
// holds a scoreboard class that predicts every result from its own copy of the ramp state
// depends on pft_pkg for payload types, command codes and register indexes
`default_nettype none

import pft_pkg::*;

// predicts the result of each accepted transfer and checks the block's results in order
class lamp_fade_checker;
	logic [LEVEL_BITS-1:0] max_level;
	logic [TICK_BITS-1:0]  ramp_ticks;
	logic [LEVEL_BITS-1:0] settled;
	logic [LEVEL_BITS-1:0] target;
	logic [LEVEL_BITS-1:0] duty;
	logic [LEVEL_BITS:0]   working;
	logic [TICK_BITS-1:0]  ticks;
	logic [TICK_BITS-1:0]  step;
	logic                  going_up;
	logic                  ramping;
	logic                  lamp_on;
	logic                  off_pending;
	out_item_t             pending_results[$];
	int unsigned           errors;
	int unsigned           checked;
	int unsigned           ramps_finished;
	int unsigned           dropped_cmds;

	function new();
		max_level      = MAX_LEVEL_RESET;
		ramp_ticks     = RAMP_TICKS_RESET;
		settled        = '0;
		target         = '0;
		duty           = '0;
		working        = '0;
		ticks          = '0;
		step           = TICK_BITS'(1);
		going_up       = 1'b1;
		ramping        = 1'b0;
		lamp_on        = 1'b0;
		off_pending    = 1'b0;
		errors         = 0;
		checked        = 0;
		ramps_finished = 0;
		dropped_cmds   = 0;
	endfunction

	function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		if (idx == CFG_MAX_LEVEL)
			max_level = data[LEVEL_BITS-1:0];
		else
			ramp_ticks = data[TICK_BITS-1:0];
	endfunction

	function void predict_transfer(in_item_t it);
		logic [TICK_BITS-1:0]  len;
		logic [TICK_BITS-1:0]  pos;
		logic [LEVEL_BITS-1:0] diff;
		logic [PCT_BITS-1:0]   pct;
		logic                  done;
		logic                  dropped;
		out_item_t             res;
		len     = (ramp_ticks == '0) ? TICK_BITS'(1) : ramp_ticks;
		done    = 1'b0;
		dropped = 1'b0;
		case (it.kind)
			KIND_TICK: begin
				if (ramping) begin
					ticks = ticks + 1'b1;
					if (going_up)
						pos = ticks;
					else
						pos = (ticks <= len) ? len - ticks : '0;
					if (pos % step == '0) begin
						if (going_up) begin
							if (working < target)
								working = working + 1'b1;
						end else begin
							if (working > target)
								working = working - 1'b1;
						end
						duty = working[LEVEL_BITS-1:0];
					end
					if (ticks >= len || ticks == '0) begin
						duty    = target;
						working = target;
						settled = target;
						ramping = 1'b0;
						if (off_pending)
							lamp_on = 1'b0;
						off_pending = 1'b0;
						done        = 1'b1;
					end
				end
			end
			KIND_FADE, KIND_OFF: begin
				if (ramping) begin
					dropped = 1'b1;
				end else begin
					lamp_on = 1'b1;
					pct     = (it.kind == KIND_OFF) ? '0 : it.percent;
					if (pct > PCT_MAX)
						pct = PCT_MAX;
					target = LEVEL_BITS'((32'(max_level) * 32'(pct)) / 32'd100);
					if (target != settled) begin
						going_up = target > settled;
						diff     = going_up ? target - settled : settled - target;
						step     = len / TICK_BITS'(diff);
						if (step == '0)
							step = TICK_BITS'(1);
						working     = settled;
						ticks       = '0;
						off_pending = (it.kind == KIND_OFF);
						ramping     = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		ramps_finished += done;
		dropped_cmds   += dropped;
		res.duty        = duty;
		res.busy_res    = ramping;
		res.lamp_enable = lamp_on;
		res.ramp_done   = done;
		res.ignored     = dropped;
		pending_results.push_back(res);
	endfunction

	function void compare_result(out_item_t got);
		out_item_t want;
		if (pending_results.size() == 0) begin
			$error("result transfer with nothing expected: duty %0d", got.duty);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		checked++;
		if (got.duty !== want.duty) begin
			$error("duty: expected %0d, got %0d", want.duty, got.duty);
			errors++;
		end
		if (got.busy_res !== want.busy_res) begin
			$error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
			errors++;
		end
		if (got.lamp_enable !== want.lamp_enable) begin
			$error("lamp_enable: expected %0b, got %0b", want.lamp_enable, got.lamp_enable);
			errors++;
		end
		if (got.ramp_done !== want.ramp_done) begin
			$error("ramp_done: expected %0b, got %0b", want.ramp_done, got.ramp_done);
			errors++;
		end
		if (got.ignored !== want.ignored) begin
			$error("ignored: expected %0b, got %0b", want.ignored, got.ignored);
			errors++;
		end
	endfunction
endclass

module tb_pwm_fade_to_level;

	// number of random input transfers after the directed part
	localparam int unsigned RANDOM_ITEMS = 1600;
	// the last stretch of the run goes without any idling on either side
	localparam int unsigned QUIET_TAIL   = 200;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	in_item_t                 in_item   = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	out_item_t                out_item;

	lamp_fade_checker model = new();
	int unsigned      sent  = 0;
	bit               quiet = 1'b0;

	pwm_fade_to_level u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// 2 time unit clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// reset held from the start, released once and never asserted again
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// hard stop in case the block hangs
	initial begin
		#3000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// result side: every completed transfer is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			model.compare_result(out_item);
	end

	// result side back-pressure: random stall bursts between ready stretches of
	// varying length, always ready once the tail is reached
	initial begin
		@(posedge arst_n);
		forever begin
			if (quiet || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				repeat (quiet ? 1 : $urandom_range(1, 40)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	function automatic in_item_t cmd_item(kind_t k, int unsigned pct);
		in_item_t it;
		it.kind    = k;
		it.percent = PCT_BITS'(pct);
		return it;
	endfunction

	// one input transfer, with an optional idle burst ahead of it; the
	// prediction is made at the edge where the transfer completes
	task automatic push(input in_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		model.predict_transfer(it);
		sent++;
	endtask

	// drop valid and wait until every predicted result has been transferred
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (model.pending_results.size() != 0) @(posedge clk);
	endtask

	// register write; the spare edge at the end keeps consecutive writes apart
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
	                         input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		model.set_register(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one well-formed fade: a command or a no-op, then ticks until the predicted ramp
	// has ended, with the odd command or no-op thrown in while it runs, and up to two ticks after
	task automatic run_fade();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 12)
			push(cmd_item(KIND_FADE, $urandom_range(0, 99)));
		else if (r < 14)
			push(cmd_item(KIND_FADE, $urandom_range(0, 127)));
		else if (r < 18)
			push(cmd_item(KIND_OFF, $urandom_range(0, 127)));
		else
			push(cmd_item(KIND_NOP, $urandom_range(0, 127)));
		while (model.ramping) begin
			if ($urandom_range(0, 9) == 0)
				push(cmd_item(kind_t'(2'($urandom_range(1, 3))), $urandom_range(0, 127)));
			else
				push(cmd_item(KIND_TICK, $urandom_range(0, 127)));
		end
		repeat ($urandom_range(0, 2)) push(cmd_item(KIND_TICK, $urandom_range(0, 127)));
	endtask

	initial begin
		int unsigned phase;
		int unsigned phase_end;
		int unsigned total;
		logic [LEVEL_BITS-1:0] lvl;
		logic [TICK_BITS-1:0]  len;

		@(posedge arst_n);
		@(posedge clk);

		// directed part, starting on the reset register values
		push(cmd_item(KIND_TICK, 0));      // tick while idle
		push(cmd_item(KIND_NOP, 127));     // no-op code
		push(cmd_item(KIND_FADE, 0));      // command at the current level
		push(cmd_item(KIND_OFF, 99));      // off at the current level, enable stays high
		push(cmd_item(KIND_FADE, 50));     // long upward ramp on the reset length
		repeat (3) push(cmd_item(KIND_TICK, 127));
		push(cmd_item(KIND_FADE, 10));     // dropped, ramp in progress
		// shorten the ramp below the count already reached
		wait_idle();
		write_reg(CFG_RAMP_TICKS, CFG_DATA_BITS'(2));
		push(cmd_item(KIND_TICK, 0));
		// longest ramp, downward, then cut short so the position passes zero
		wait_idle();
		write_reg(CFG_RAMP_TICKS, CFG_DATA_BITS'(16777215));
		push(cmd_item(KIND_OFF, 0));
		repeat (2) push(cmd_item(KIND_TICK, 85));
		push(cmd_item(KIND_OFF, 42));      // dropped as well
		wait_idle();
		write_reg(CFG_RAMP_TICKS, CFG_DATA_BITS'(1));
		push(cmd_item(KIND_TICK, 0));      // ends the off ramp, enable drops
		// zero length acts as one tick; percent above 99 saturates
		wait_idle();
		write_reg(CFG_RAMP_TICKS, '0);
		write_reg(CFG_MAX_LEVEL, CFG_DATA_BITS'(65535));
		push(cmd_item(KIND_FADE, 127));
		push(cmd_item(KIND_TICK, 0));
		push(cmd_item(KIND_FADE, 99));     // same level again
		// smallest full scale: every target collapses to zero
		wait_idle();
		write_reg(CFG_MAX_LEVEL, CFG_DATA_BITS'(1));
		write_reg(CFG_RAMP_TICKS, CFG_DATA_BITS'(3));
		push(cmd_item(KIND_FADE, 99));
		repeat (3) push(cmd_item(KIND_TICK, 0));
		push(cmd_item(KIND_NOP, 0));

		// random part in phases, each on its own register setting
		total = sent + RANDOM_ITEMS;
		phase = 0;
		while (sent < total) begin
			wait_idle();
			case (phase)
				0: begin
					lvl = LEVEL_BITS'(65535);
					len = TICK_BITS'(1);
				end
				1: begin
					lvl = LEVEL_BITS'(1);
					len = TICK_BITS'(48);
				end
				default: begin
					// small full scales give step sizes above one
					case ($urandom_range(0, 4))
						0: lvl = LEVEL_BITS'(1);
						1: lvl = LEVEL_BITS'(65535);
						2: lvl = LEVEL_BITS'($urandom_range(2, 60));
						3: lvl = LEVEL_BITS'($urandom_range(61, 5000));
						default: lvl = LEVEL_BITS'($urandom_range(1, 65535));
					endcase
					len = TICK_BITS'($urandom_range(0, 48));
				end
			endcase
			write_reg(CFG_MAX_LEVEL, CFG_DATA_BITS'(lvl));
			write_reg(CFG_RAMP_TICKS, CFG_DATA_BITS'(len));
			phase_end = sent + $urandom_range(150, 250);
			while (sent < phase_end && sent < total) begin
				quiet = (sent + QUIET_TAIL >= total);
				run_fade();
			end
			phase++;
		end

		// drain, then allow for a stray late result
		wait_idle();
		repeat (120) @(posedge clk);
		if (model.pending_results.size() != 0) begin
			$error("%0d results never arrived", model.pending_results.size());
			model.errors++;
		end

		$display("run: %0d transfers in over %0d register settings, %0d results checked",
			sent, phase + 6, model.checked);
		$display("run: %0d ramps finished, %0d commands dropped during a ramp",
			model.ramps_finished, model.dropped_cmds);
		if (model.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
